// ----- hw/rtl/rdl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdl_pkg
// shared types and constants of the reversible deque list engine
// ----------------------------------------------------------------------------
package rdl_pkg;

    localparam int VALUE_W       = 14;
    localparam int CHAR_W        = 8;
    localparam int DEFAULT_DEPTH = 64;

    localparam logic [VALUE_W-1:0] VALUE_MAX = 14'd9999;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'd57;
    localparam logic [CHAR_W-1:0] CHAR_R     = 8'h52;
    localparam logic [CHAR_W-1:0] CHAR_COMMA = 8'h2C;
    localparam logic [CHAR_W-1:0] CHAR_CLOSE = 8'h5D;

    localparam logic [3:0] DIGIT_BASE = 4'd10;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_LIST  = 2'd1,
        OP_CMD   = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    typedef struct packed {
        op_t               opcode;
        logic [CHAR_W-1:0] char_in;
    } item_t;

    typedef struct packed {
        logic               push;
        logic [VALUE_W-1:0] value;
    } push_t;

    typedef struct packed {
        logic               valid_res;
        logic [VALUE_W-1:0] value;
        logic               last;
        logic               error;
    } result_t;

endpackage

// ----- hw/rtl/rdl_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdl_in_if / rdl_out_if
// valid/ready channels for operation beats and result beats
// ----------------------------------------------------------------------------
interface rdl_in_if;
    import rdl_pkg::*;

    logic              valid;
    logic              ready;
    logic [1:0]        opcode;
    logic [CHAR_W-1:0] char_in;

    modport source (output valid, output opcode, output char_in, input ready);
    modport sink (input valid, input opcode, input char_in, output ready);
endinterface

interface rdl_out_if;
    import rdl_pkg::*;

    logic               valid;
    logic               ready;
    logic               valid_res;
    logic [VALUE_W-1:0] value;
    logic               last;
    logic               error;

    modport source (output valid, output valid_res, output value, output last,
                    output error, input ready);
    modport sink (input valid, input valid_res, input value, input last,
                  input error, output ready);
endinterface

// ----- hw/rtl/rdl_parse.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdl_parse
// decimal list parser: accumulates digits and, once digits are seen, raises a push on a separator
// ----------------------------------------------------------------------------
module rdl_parse (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           accept,
    input  rdl_pkg::item_t item,
    output rdl_pkg::push_t push_req
);
    import rdl_pkg::*;

    localparam int PROD_W = VALUE_W + 3;

    logic [VALUE_W-1:0] acc_reg;
    logic [VALUE_W-1:0] acc_next;
    logic               seen_reg;
    logic               seen_next;
    logic               is_digit;
    logic               is_sep;
    logic [PROD_W-1:0]  acc_sum;

    assign is_digit = (item.char_in >= CHAR_ZERO) && (item.char_in <= CHAR_NINE);
    assign is_sep   = (item.char_in == CHAR_COMMA) || (item.char_in == CHAR_CLOSE);

    // acc*10 + digit, at most 99999, fits 17 bits
    assign acc_sum = PROD_W'(acc_reg) * PROD_W'(DIGIT_BASE)
                   + PROD_W'(item.char_in - CHAR_ZERO);

    always_comb
    begin
        acc_next  = acc_reg;
        seen_next = seen_reg;
        if (accept)
        begin
            // commands, reads and other list characters leave the parser alone
            if (item.opcode == OP_CLEAR)
            begin
                acc_next  = '0;
                seen_next = 1'b0;
            end
            else if (item.opcode == OP_LIST && is_digit)
            begin
                acc_next  = (acc_sum > PROD_W'(VALUE_MAX)) ? VALUE_MAX
                                                           : acc_sum[VALUE_W-1:0];
                seen_next = 1'b1;
            end
            else if (item.opcode == OP_LIST && is_sep)
            begin
                acc_next  = '0;
                seen_next = 1'b0;
            end
        end
    end

    assign push_req.push  = accept && (item.opcode == OP_LIST) && is_sep && seen_reg;
    assign push_req.value = acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            seen_reg <= 1'b0;
        end
        else
        begin
            acc_reg  <= acc_next;
            seen_reg <= seen_next;
        end
    end

endmodule

// ----- hw/rtl/rdl_deque.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdl_deque
// circular element store with head/count pointers, reverse and error flags
// ----------------------------------------------------------------------------
module rdl_deque #(
    parameter int DEPTH = rdl_pkg::DEFAULT_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  rdl_pkg::item_t   item,
    input  rdl_pkg::push_t   push_req,
    output rdl_pkg::result_t result
);
    import rdl_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    logic [VALUE_W-1:0] mem [DEPTH];

    logic [PTR_W-1:0]   head_reg;
    logic [PTR_W-1:0]   head_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               rev_reg;
    logic               rev_next;
    logic               err_reg;
    logic               err_next;
    logic               valid_res_reg;
    logic               valid_res_next;
    logic               last_reg;
    logic               last_next;
    logic [VALUE_W-1:0] rd_data_reg;

    logic [SUM_W-1:0]   tail_sum;
    logic [SUM_W-1:0]   tail_wrap;
    logic [SUM_W-1:0]   back_sum;
    logic [SUM_W-1:0]   back_wrap;
    logic [SUM_W-1:0]   inc_sum;
    logic [SUM_W-1:0]   inc_wrap;
    logic [PTR_W-1:0]   rd_addr;
    logic               empty;
    logic               full;
    logic               do_pop;
    logic               do_write;

    // physical back slot (next free) and last live slot, mod DEPTH
    assign tail_sum  = SUM_W'(head_reg) + SUM_W'(count_reg);
    assign tail_wrap = (tail_sum >= SUM_W'(DEPTH)) ? tail_sum - SUM_W'(DEPTH) : tail_sum;
    assign back_sum  = tail_sum - SUM_W'(1);
    assign back_wrap = (back_sum >= SUM_W'(DEPTH)) ? back_sum - SUM_W'(DEPTH) : back_sum;
    assign inc_sum   = SUM_W'(head_reg) + SUM_W'(1);
    assign inc_wrap  = (inc_sum >= SUM_W'(DEPTH)) ? inc_sum - SUM_W'(DEPTH) : inc_sum;

    // logical front sits at the physical back while reversed
    assign rd_addr = rev_reg ? back_wrap[PTR_W-1:0] : head_reg;
    assign empty   = (count_reg == '0);
    assign full    = (count_reg >= CNT_W'(DEPTH));

    always_comb
    begin
        head_next      = head_reg;
        count_next     = count_reg;
        rev_next       = rev_reg;
        err_next       = err_reg;
        valid_res_next = 1'b0;
        last_next      = 1'b0;
        do_pop         = 1'b0;
        do_write       = 1'b0;
        if (accept)
        begin
            unique case (item.opcode)
                OP_CLEAR:
                begin
                    head_next  = '0;
                    count_next = '0;
                    rev_next   = 1'b0;
                    err_next   = 1'b0;
                end
                OP_LIST:
                begin
                    if (push_req.push)
                    begin
                        if (full)
                        begin
                            err_next = 1'b1;
                        end
                        else
                        begin
                            do_write   = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                end
                OP_CMD:
                begin
                    priority if (item.char_in == CHAR_R)
                    begin
                        rev_next = !rev_reg;
                    end
                    else if (empty)
                    begin
                        err_next = 1'b1;
                    end
                    else
                    begin
                        do_pop = 1'b1;
                    end
                end
                OP_READ:
                begin
                    priority if (err_reg)
                    begin
                        valid_res_next = 1'b0;
                    end
                    else if (empty)
                    begin
                        last_next = 1'b1;
                    end
                    else
                    begin
                        do_pop         = 1'b1;
                        valid_res_next = 1'b1;
                        last_next      = (count_reg == CNT_W'(1));
                    end
                end
            endcase
            if (do_pop)
            begin
                count_next = count_reg - CNT_W'(1);
                if (!rev_reg)
                begin
                    head_next = inc_wrap[PTR_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            rev_reg       <= 1'b0;
            err_reg       <= 1'b0;
            valid_res_reg <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
            rev_reg   <= rev_next;
            err_reg   <= err_next;
            if (accept)
            begin
                valid_res_reg <= valid_res_next;
                last_reg      <= last_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            mem[tail_wrap[PTR_W-1:0]] <= push_req.value;
        end
        if (accept)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign result.valid_res = valid_res_reg;
    assign result.value     = valid_res_reg ? rd_data_reg : '0;
    assign result.last      = last_reg;
    assign result.error     = err_reg;

endmodule

// ----- hw/rtl/reversible_deque_list_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reversible_deque_list_engine
// bounded deque of decimal values fed from bracketed list text, with lazy
// reverse, front removal, reads and a sticky error flag
// ----------------------------------------------------------------------------
// One operation beat is taken per cycle and its result beat appears in the
// output register on the next cycle, so sustained throughput is one beat per
// clock while the sink does not stall. The element store is a single DEPTH-entry
// memory with one write and one registered read per cycle; its contents need
// no clearing after reset since only live entries are read. A result that the
// sink has not taken holds the input off until it is taken.
// ----------------------------------------------------------------------------
module reversible_deque_list_engine #(
    parameter int DEPTH = rdl_pkg::DEFAULT_DEPTH
) (
    input logic      clk,
    input logic      rst_n,
    rdl_in_if.sink   in_ch,
    rdl_out_if.source out_ch
);
    import rdl_pkg::*;

    logic    out_valid_reg;
    logic    out_valid_next;
    logic    accept;
    item_t   item;
    push_t   push_req;
    result_t result;

    assign in_ch.ready  = !out_valid_reg || out_ch.ready;
    assign accept       = in_ch.valid && in_ch.ready;
    assign item.opcode  = op_t'(in_ch.opcode);
    assign item.char_in = in_ch.char_in;

    rdl_parse u_parse (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .item     (item),
        .push_req (push_req)
    );

    rdl_deque #(
        .DEPTH (DEPTH)
    ) u_deque (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .item     (item),
        .push_req (push_req),
        .result   (result)
    );

    // result beat stays until taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.valid_res = result.valid_res;
    assign out_ch.value     = result.value;
    assign out_ch.last      = result.last;
    assign out_ch.error     = result.error;

    a_accept_gives_beat: assert property (
        @(posedge clk) disable iff (!rst_n)
        accept |=> out_ch.valid
    ) else $error("accepted beat did not produce a result");

    a_clear_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        (accept && item.opcode == OP_CLEAR) |=>
            (!out_ch.error && !out_ch.valid_res && !out_ch.last)
    ) else $error("clear result not clean");

    a_pop_not_with_error: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.valid_res) |-> !out_ch.error
    ) else $error("element given while error is set");

    a_value_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (out_ch.value <= VALUE_MAX)
    ) else $error("value beyond saturation limit");

endmodule

// ----- tb/reversible_deque_list_engine_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reversible_deque_list_engine_test
// Drives operation beats into the deque engine and checks every result beat
// against a cycle-free model of the deque or, for typed directed rows, against
// the row's expected beat. The run opens with a table of directed beats and
// then sends random list text, commands, reads, clears and noise. Random idling
// and stalls on both sides, one long output stall and one full drain are part of the run.
// ----------------------------------------------------------------------------
module reversible_deque_list_engine_test;
    import rdl_pkg::*;

    localparam int DEPTH      = DEFAULT_DEPTH;
    localparam int ITEM_GOAL  = 1700;
    localparam int QUIET_FROM = 1500;
    localparam int HOLD_AT    = 500;
    localparam int DRAIN_AT   = 900;
    localparam int HOLD_LEN   = 300;
    localparam int EXP_DEPTH  = 16;

    localparam logic [CHAR_W-1:0] CHAR_OPEN = 8'h5B;
    localparam logic [CHAR_W-1:0] CHAR_DEL  = 8'h44;

    localparam result_t RES_NONE  = '0;
    localparam result_t RES_EMPTY = {1'b0, 14'd0, 1'b1, 1'b0};
    localparam result_t RES_ERR   = {1'b0, 14'd0, 1'b0, 1'b1};

    typedef struct packed {
        op_t               op;
        logic [CHAR_W-1:0] ch;
        logic              typed;
        result_t           want;
    } stim_row_t;

    // directed opening: empty read, error handling, saturation, separators,
    // ignored characters, reverse and delete
    localparam int N_ROWS = 26;
    localparam stim_row_t DIRECTED_ROWS [N_ROWS] = '{
        {OP_READ,  8'h00,           1'b1, RES_EMPTY},
        {OP_CMD,   8'hFF,           1'b1, RES_ERR},
        {OP_READ,  8'hFF,           1'b1, RES_ERR},
        {OP_CMD,   CHAR_R,          1'b1, RES_ERR},
        {OP_CLEAR, 8'hFF,           1'b1, RES_NONE},
        {OP_LIST,  CHAR_OPEN,       1'b1, RES_NONE},
        {OP_LIST,  CHAR_NINE,       1'b1, RES_NONE},
        {OP_LIST,  CHAR_NINE,       1'b1, RES_NONE},
        {OP_LIST,  CHAR_NINE,       1'b1, RES_NONE},
        {OP_LIST,  CHAR_NINE,       1'b1, RES_NONE},
        {OP_LIST,  CHAR_NINE,       1'b1, RES_NONE},
        {OP_LIST,  CHAR_COMMA,      1'b1, RES_NONE},
        {OP_LIST,  CHAR_ZERO,       1'b1, RES_NONE},
        {OP_LIST,  CHAR_CLOSE,      1'b1, RES_NONE},
        {OP_LIST,  CHAR_COMMA,      1'b1, RES_NONE},
        {OP_LIST,  8'h00,           1'b1, RES_NONE},
        {OP_LIST,  8'hFF,           1'b1, RES_NONE},
        {OP_LIST,  CHAR_ZERO + 8'd7, 1'b0, RES_NONE},
        {OP_LIST,  8'hAA,           1'b0, RES_NONE},
        {OP_LIST,  CHAR_CLOSE,      1'b0, RES_NONE},
        {OP_CMD,   CHAR_R,          1'b0, RES_NONE},
        {OP_READ,  8'h00,           1'b1, {1'b1, 14'd7, 1'b0, 1'b0}},
        {OP_CMD,   8'h00,           1'b0, RES_NONE},
        {OP_CMD,   CHAR_R,          1'b0, RES_NONE},
        {OP_READ,  8'h55,           1'b1, {1'b1, 14'd9999, 1'b1, 1'b0}},
        {OP_READ,  8'hFF,           1'b1, RES_EMPTY}
    };

    logic clk;
    logic rst_n;

    rdl_in_if  in_ch ();
    rdl_out_if out_ch ();

    reversible_deque_list_engine #(
        .DEPTH(DEPTH)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch),
        .out_ch(out_ch)
    );

    // deque model state
    logic [VALUE_W-1:0] slot_mem [DEPTH];
    int unsigned        front_ptr;
    int unsigned        fill_count;
    bit                 reverse_on;
    bit                 sticky_err;
    int unsigned        number_acc;
    bit                 digit_pending;

    // expected result beats in order; writer and reader each own a counter
    result_t     exp_fifo [EXP_DEPTH];
    int unsigned exp_wr_cnt;
    int unsigned exp_rd_cnt;

    int  failures;
    int  items_accepted;
    int  results_checked;
    int  values_popped;
    int  full_drops;
    int  empty_deletes;
    int  saturations;
    bit  quiet;
    bit  sender_calm;
    bit  hold_request;

    function automatic logic [VALUE_W-1:0] take_front();
        logic [VALUE_W-1:0] v;
        if (!reverse_on)
        begin
            v = slot_mem[front_ptr];
            front_ptr = (front_ptr + 1) % DEPTH;
        end
        else
        begin
            v = slot_mem[(front_ptr + fill_count - 1) % DEPTH];
        end
        fill_count--;
        return v;
    endfunction

    function automatic result_t step_deque(op_t op, logic [CHAR_W-1:0] ch);
        result_t     r;
        int unsigned sum;
        r = '0;
        case (op)
            OP_CLEAR:
            begin
                front_ptr     = 0;
                fill_count    = 0;
                reverse_on    = 1'b0;
                sticky_err    = 1'b0;
                number_acc    = 0;
                digit_pending = 1'b0;
            end
            OP_LIST:
            begin
                if (ch >= CHAR_ZERO && ch <= CHAR_NINE)
                begin
                    sum = number_acc * 10 + (ch - CHAR_ZERO);
                    if (sum > VALUE_MAX)
                    begin
                        number_acc = VALUE_MAX;
                        saturations++;
                    end
                    else
                    begin
                        number_acc = sum;
                    end
                    digit_pending = 1'b1;
                end
                else if (ch == CHAR_COMMA || ch == CHAR_CLOSE)
                begin
                    if (digit_pending)
                    begin
                        if (fill_count >= DEPTH)
                        begin
                            sticky_err = 1'b1;
                            full_drops++;
                        end
                        else
                        begin
                            slot_mem[(front_ptr + fill_count) % DEPTH] = number_acc[VALUE_W-1:0];
                            fill_count++;
                        end
                    end
                    number_acc    = 0;
                    digit_pending = 1'b0;
                end
            end
            OP_CMD:
            begin
                if (ch == CHAR_R)
                begin
                    reverse_on = !reverse_on;
                end
                else if (fill_count == 0)
                begin
                    sticky_err = 1'b1;
                    empty_deletes++;
                end
                else
                begin
                    void'(take_front());
                end
            end
            default:
            begin
                if (sticky_err)
                begin
                    // read is refused while the error stands
                end
                else if (fill_count == 0)
                begin
                    r.last = 1'b1;
                end
                else
                begin
                    r.value     = take_front();
                    r.valid_res = 1'b1;
                    r.last      = (fill_count == 0);
                    values_popped++;
                end
            end
        endcase
        r.error = sticky_err;
        return r;
    endfunction

    // one operation beat; the model runs at the edge where the beat is taken
    task automatic offer(input op_t op, input logic [CHAR_W-1:0] ch,
                         input logic typed = 1'b0, input result_t want = '0);
        result_t predicted;
        if (!quiet && !sender_calm && $urandom_range(0, 5) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.opcode  <= op;
        in_ch.char_in <= ch;
        do
            @(posedge clk);
        while (!in_ch.ready);
        predicted = step_deque(op, ch);
        exp_fifo[exp_wr_cnt % EXP_DEPTH] = typed ? want : predicted;
        exp_wr_cnt++;
        items_accepted++;
    endtask

    // bracketed list of n_values numbers, now and then with a stray character
    task automatic send_number_list(input int n_values);
        int digits;
        offer(OP_LIST, CHAR_OPEN);
        for (int i = 0; i < n_values; i++)
        begin
            digits = ($urandom_range(0, 15) == 0) ? $urandom_range(5, 7) : $urandom_range(1, 4);
            repeat (digits) offer(OP_LIST, CHAR_ZERO + 8'($urandom_range(0, 9)));
            if ($urandom_range(0, 19) == 0)
                offer(OP_LIST, 8'($urandom_range(0, 255)));
            offer(OP_LIST, (i == n_values - 1) ? CHAR_CLOSE : CHAR_COMMA);
        end
        if (n_values == 0)
            offer(OP_LIST, CHAR_CLOSE);
    endtask

    task automatic report_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            failures++;
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // result sink: random stall bursts plus one long hold on request
    initial
    begin
        out_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        out_ch.ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (HOLD_LEN) @(posedge clk);
                out_ch.ready <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 11) == 0)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (exp_wr_cnt == exp_rd_cnt)
            begin
                $display("%0t: result beat with nothing expected, actual %0d/%0d/%0d/%0d",
                         $time, out_ch.valid_res, out_ch.value, out_ch.last, out_ch.error);
                failures++;
            end
            else
            begin
                want = exp_fifo[exp_rd_cnt % EXP_DEPTH];
                exp_rd_cnt++;
                report_field("valid_res", 32'(want.valid_res), 32'(out_ch.valid_res));
                report_field("value", 32'(want.value), 32'(out_ch.value));
                report_field("last", 32'(want.last), 32'(out_ch.last));
                report_field("error", 32'(want.error), 32'(out_ch.error));
                results_checked++;
            end
        end
    end

    initial
    begin
        int  pick;
        bit  hold_done;
        bit  drain_done;
        stim_row_t row;

        hold_done     = 1'b0;
        drain_done    = 1'b0;
        failures      = 0;
        items_accepted  = 0;
        results_checked = 0;
        values_popped = 0;
        full_drops    = 0;
        empty_deletes = 0;
        saturations   = 0;
        quiet         = 1'b0;
        sender_calm   = 1'b0;
        hold_request  = 1'b0;
        front_ptr     = 0;
        fill_count    = 0;
        reverse_on    = 1'b0;
        sticky_err    = 1'b0;
        number_acc    = 0;
        digit_pending = 1'b0;

        rst_n         <= 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.opcode  <= OP_CLEAR;
        in_ch.char_in <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_ROWS; i++)
        begin
            row = DIRECTED_ROWS[i];
            offer(row.op, row.ch, row.typed, row.want);
        end

        while (items_accepted < ITEM_GOAL)
        begin
            pick        = $urandom_range(0, 99);
            sender_calm = ($urandom_range(0, 3) == 0);
            if (items_accepted >= QUIET_FROM)
                quiet = 1'b1;
            if (!hold_done && items_accepted >= HOLD_AT)
            begin
                hold_request = 1'b1;
                hold_done    = 1'b1;
            end
            if (!drain_done && items_accepted >= DRAIN_AT)
            begin
                in_ch.valid <= 1'b0;
                while (exp_wr_cnt != exp_rd_cnt) @(posedge clk);
                drain_done = 1'b1;
            end

            if (sticky_err && pick < 50)
                offer(OP_CLEAR, 8'($urandom_range(0, 255)));
            else if (pick < 3)
                send_number_list($urandom_range(DEPTH + 1, DEPTH + 6));
            else if (pick < 40)
                send_number_list($urandom_range(0, 8));
            else if (pick < 65)
                repeat ($urandom_range(1, 10)) offer(OP_READ, 8'($urandom_range(0, 255)));
            else if (pick < 85)
                repeat ($urandom_range(1, 4))
                    offer(OP_CMD, ($urandom_range(0, 2) == 0) ? CHAR_R :
                          (($urandom_range(0, 3) == 0) ? CHAR_DEL : 8'($urandom_range(0, 255))));
            else if (pick < 88)
                offer(OP_CLEAR, 8'($urandom_range(0, 255)));
            else
                repeat ($urandom_range(1, 3))
                    offer(op_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        end

        in_ch.valid <= 1'b0;
        while (exp_wr_cnt != exp_rd_cnt) @(posedge clk);
        repeat (8) @(posedge clk);

        $display("covered %0d operation beats and %0d result beats, %0d values read out",
                 items_accepted, results_checked, values_popped);
        $display("saturated digits %0d, pushes into full deque %0d, deletes on empty %0d",
                 saturations, full_drops, empty_deletes);
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
